[hdl/iirhp_pkg.sv]
// ----------------------------------------------------------------------------
// iirhp_pkg
// Shared types and constants of the high-pass filter core: word widths,
// fixed-point scaling, mode codes, register map and the history record.
// ----------------------------------------------------------------------------
package iirhp_pkg;

    localparam int COEF_FRAC_BITS = 16;
    localparam int HIST_FRAC_BITS = 20;
    localparam int SAMPLE_W       = 16;
    localparam int SAMPLE_FRAC    = 15;
    localparam int HIST_W         = 24;
    localparam int COEF_U_W       = 17;
    localparam int COEF_S_W       = 18;
    localparam int MODE_W         = 2;

    // scale between the sample grid and the history grid
    localparam int HIST_SHIFT = HIST_FRAC_BITS - SAMPLE_FRAC;

    localparam logic [MODE_W-1:0] MODE_BYPASS     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SECOND     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SECOND_ALT = 2'd3;

    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;
    localparam int PDATA_W   = 32;

    localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_FIRST = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_B0    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_A1    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_A2    = 3'd4;

    localparam logic [COEF_U_W-1:0] COEF_B0_RESET = 17'd65536;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic [COEF_U_W-1:0]        first;
        logic [COEF_U_W-1:0]        b0;
        logic signed [COEF_S_W-1:0] a1;
        logic signed [COEF_S_W-1:0] a2;
    } coef_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [HIST_W-1:0]   y1;
        logic signed [HIST_W-1:0]   y2;
    } hist_t;

endpackage

[hdl/iirhp_calc.sv]
// ----------------------------------------------------------------------------
// iirhp_calc
// One filter step: forms the first- or second-order accumulator, rounds and
// saturates it into the y history, and rounds y back to a Q1.15 sample.
// ----------------------------------------------------------------------------
module iirhp_calc (
    input  iirhp_pkg::coef_t                   coef,
    input  iirhp_pkg::hist_t                   hist,
    input  logic signed [iirhp_pkg::SAMPLE_W-1:0] x,
    output iirhp_pkg::hist_t                   hist_next,
    output logic signed [iirhp_pkg::SAMPLE_W-1:0] sample_next
);
    import iirhp_pkg::*;

    localparam int DX_W   = SAMPLE_W + 1;
    localparam int DXS_W  = DX_W + HIST_SHIFT;
    localparam int S_W    = ((DXS_W > HIST_W) ? DXS_W : HIST_W) + 1;
    localparam int FF_W   = SAMPLE_W + 2;
    localparam int FFS_W  = FF_W + HIST_SHIFT;
    localparam int P1_W   = S_W + COEF_U_W + 1;
    localparam int PB_W   = FFS_W + COEF_U_W + 1;
    localparam int PA_W   = HIST_W + COEF_S_W;
    localparam int PM_W   = (P1_W > PB_W) ? P1_W : PB_W;
    localparam int ACC_W  = ((PM_W > PA_W) ? PM_W : PA_W) + 2;
    localparam int YR_W   = HIST_W + 1;

    logic signed [DX_W-1:0]     dx;
    logic signed [S_W-1:0]      s_sum;
    logic signed [P1_W-1:0]     p_first;
    logic signed [FF_W-1:0]     ff;
    logic signed [FFS_W-1:0]    ff_scaled;
    logic signed [PB_W-1:0]     p_b0;
    logic signed [PA_W-1:0]     p_a1;
    logic signed [PA_W-1:0]     p_a2;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [ACC_W-1:0]    y_wide;
    logic signed [HIST_W-1:0]   y;
    logic signed [YR_W-1:0]     y_rnd;
    logic signed [YR_W-1:0]     o_wide;
    logic signed [SAMPLE_W-1:0] o_sat;

    // first order: a * (y1 + (x - x1) scaled to the history grid)
    assign dx      = DX_W'(x) - DX_W'($signed(hist.x1));
    assign s_sum   = S_W'($signed(hist.y1)) + (S_W'(dx) <<< HIST_SHIFT);
    assign p_first = s_sum * $signed({1'b0, coef.first});

    // second order: b0 * (x - 2*x1 + x2) - a1*y1 - a2*y2
    assign ff        = FF_W'(x) - (FF_W'($signed(hist.x1)) <<< 1) + FF_W'($signed(hist.x2));
    assign ff_scaled = FFS_W'(ff) <<< HIST_SHIFT;
    assign p_b0      = ff_scaled * $signed({1'b0, coef.b0});
    assign p_a1      = $signed(coef.a1) * $signed(hist.y1);
    assign p_a2      = $signed(coef.a2) * $signed(hist.y2);

    always_comb
    begin
        case (coef.mode)
            MODE_FIRST:
            begin
                acc = ACC_W'(p_first);
            end
            default:
            begin
                acc = ACC_W'(p_b0) - ACC_W'(p_a1) - ACC_W'(p_a2);
            end
        endcase
    end

    // round half up, then saturate into the history store
    assign acc_rnd = acc + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1));
    assign y_wide  = acc_rnd >>> COEF_FRAC_BITS;

    always_comb
    begin
        if (y_wide > $signed({{(ACC_W-HIST_W+1){1'b0}}, {(HIST_W-1){1'b1}}}))
        begin
            y = $signed({1'b0, {(HIST_W-1){1'b1}}});
        end
        else if (y_wide < $signed({{(ACC_W-HIST_W+1){1'b1}}, {(HIST_W-1){1'b0}}}))
        begin
            y = $signed({1'b1, {(HIST_W-1){1'b0}}});
        end
        else
        begin
            y = y_wide[HIST_W-1:0];
        end
    end

    assign y_rnd  = YR_W'(y) + (YR_W'(1) <<< (HIST_SHIFT - 1));
    assign o_wide = y_rnd >>> HIST_SHIFT;

    always_comb
    begin
        if (o_wide > $signed({{(YR_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}}))
        begin
            o_sat = $signed({1'b0, {(SAMPLE_W-1){1'b1}}});
        end
        else if (o_wide < $signed({{(YR_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}}))
        begin
            o_sat = $signed({1'b1, {(SAMPLE_W-1){1'b0}}});
        end
        else
        begin
            o_sat = o_wide[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        hist_next   = hist;
        sample_next = o_sat;
        case (coef.mode)
            MODE_BYPASS:
            begin
                sample_next = x;
            end
            MODE_FIRST:
            begin
                hist_next.x1 = x;
                hist_next.y1 = y;
            end
            default:
            begin
                hist_next.x2 = hist.x1;
                hist_next.x1 = x;
                hist_next.y2 = hist.y1;
                hist_next.y1 = y;
            end
        endcase
    end

endmodule

[hdl/iir_highpass_filter_core.sv]
// ----------------------------------------------------------------------------
// iir_highpass_filter_core
// High-pass filter for Q1.15 audio: bypass, first-order or biquad section.
// ----------------------------------------------------------------------------
// One sample enters per beat and one filtered sample leaves per beat. An
// accepted sample is held in the input register, is filtered in a single
// pass (the multiplies and the history update of the recursion happen in
// that same cycle) and appears in the output register. The sustained rate
// is one sample per clock while the output is not stalled, set by the
// feedback through the y history. The output register and input register let
// a new sample in while a result waits. Coefficients are fixed-point
// registers on the APB port (mode at 0x00, first-order a at 0x04, b0 at
// 0x08, a1 at 0x0C, a2 at 0x10); write them only while the stream is idle.
// Bypass passes samples through and leaves the history untouched.
// ----------------------------------------------------------------------------
module iir_highpass_filter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // stream in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [iirhp_pkg::SAMPLE_W-1:0]  s_axis_tdata,   // [15:0] sample_in
    // stream out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [iirhp_pkg::SAMPLE_W-1:0]  m_axis_tdata,   // [15:0] sample_out
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [iirhp_pkg::PADDR_W-1:0]   paddr,
    input  logic [iirhp_pkg::PDATA_W-1:0]   pwdata,
    output logic [iirhp_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);
    import iirhp_pkg::*;

    coef_t                      coef_reg;
    hist_t                      hist_reg;
    hist_t                      hist_next;
    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] in_data_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic                       advance;
    logic                       cfg_write;
    logic [REG_IDX_W-1:0]       reg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.mode  <= MODE_BYPASS;
            coef_reg.first <= '0;
            coef_reg.b0    <= COEF_B0_RESET;
            coef_reg.a1    <= '0;
            coef_reg.a2    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_MODE:       coef_reg.mode  <= pwdata[MODE_W-1:0];
                REG_COEF_FIRST: coef_reg.first <= pwdata[COEF_U_W-1:0];
                REG_COEF_B0:    coef_reg.b0    <= pwdata[COEF_U_W-1:0];
                REG_COEF_A1:    coef_reg.a1    <= $signed(pwdata[COEF_S_W-1:0]);
                REG_COEF_A2:    coef_reg.a2    <= $signed(pwdata[COEF_S_W-1:0]);
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:       prdata = PDATA_W'(coef_reg.mode);
            REG_COEF_FIRST: prdata = PDATA_W'(coef_reg.first);
            REG_COEF_B0:    prdata = PDATA_W'(coef_reg.b0);
            REG_COEF_A1:    prdata = PDATA_W'(coef_reg.a1);
            REG_COEF_A2:    prdata = PDATA_W'(coef_reg.a2);
            default:        prdata = '0;
        endcase
    end

    // move the held sample on whenever the output register frees up
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    iirhp_calc u_calc (
        .coef        (coef_reg),
        .hist        (hist_reg),
        .x           (in_data_reg),
        .hist_next   (hist_next),
        .sample_next (sample_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_reg      <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    hist_reg <= hist_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= $signed(s_axis_tdata);
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= sample_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[hdl/iirhp_checker.sv]
// ----------------------------------------------------------------------------
// iirhp_checker
// Port-level checks of the filter core's stream behavior, bound to the top.
// ----------------------------------------------------------------------------
module iirhp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [iirhp_pkg::SAMPLE_W-1:0] m_axis_tdata
);
    import iirhp_pkg::*;

    // a stalled result holds its beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

    // a new result from an empty pipe follows an accepted input beat through the input register
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("output beat without matching input");

    // both stages full under a held stall: input must back-pressure
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $past(m_axis_tvalid && !m_axis_tready) && $past(s_axis_tvalid && s_axis_tready)
        && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted with both stages full");

endmodule

bind iir_highpass_filter_core iirhp_checker u_iirhp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[test/iir_highpass_filter_core_test.sv]
// ----------------------------------------------------------------------------
// iir_highpass_filter_core_test
// Self-checking bench for the high-pass filter core. It starts with a table of
// directed beats and register writes: bypass extremes, a zero coefficient,
// coefficients above one, feedback extremes, mode code three, a write to an
// unused address and masked register bits. Random phases follow. Each phase
// writes a fresh setting while the stream is idle: realistic first-order or
// biquad coefficients, bypass, or extreme values. It then streams random audio
// with random gaps on both sides. A behavioral filter predicts every output
// beat, and the bench compares each output beat with it in order.
// ----------------------------------------------------------------------------
module iir_highpass_filter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import iirhp_pkg::*;

    // the slowest correct run stays well under this limit
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 12;

    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd6;

    localparam longint HIST_UP  = longint'(1) << HIST_SHIFT;
    localparam longint Y_TOP    = (longint'(1) << (HIST_W - 1)) - 1;
    localparam longint Y_BOTTOM = -(longint'(1) << (HIST_W - 1));
    localparam longint OUT_TOP    = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint OUT_BOTTOM = -(longint'(1) << (SAMPLE_W - 1));

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [REG_IDX_W-1:0]   idx;
        logic [31:0]            value;
        logic                   known;
        logic [SAMPLE_W-1:0]    out;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [29] = '{
        // bypass after reset: samples pass unchanged
        '{ROW_SAMPLE, REG_MODE,       32'h0000_7FFF, 1'b1, 16'h7FFF},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_8000, 1'b1, 16'h8000},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_0000, 1'b1, 16'h0000},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_FFFF, 1'b1, 16'hFFFF},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_5555, 1'b1, 16'h5555},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_AAAA, 1'b1, 16'hAAAA},
        // first order with a zero coefficient gives silence
        '{ROW_WRITE,  REG_MODE,       32'(MODE_FIRST), 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_7FFF, 1'b1, 16'h0000},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_8000, 1'b1, 16'h0000},
        '{ROW_WRITE,  REG_COEF_FIRST, 32'h0001_0000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_7FFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_8000, 1'b0, 16'h0000},
        // coefficient above one, upper bits masked off
        '{ROW_WRITE,  REG_COEF_FIRST, 32'hFFFF_FFFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_7FFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_8000, 1'b0, 16'h0000},
        // biquad with feedback extremes
        '{ROW_WRITE,  REG_MODE,       32'(MODE_SECOND), 1'b0, 16'h0000},
        '{ROW_WRITE,  REG_COEF_A1,    32'hFFFE_0000, 1'b0, 16'h0000},
        '{ROW_WRITE,  REG_COEF_A2,    32'h0001_FFFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_7FFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_0001, 1'b0, 16'h0000},
        '{ROW_WRITE,  REG_COEF_B0,    32'h0001_FFFF, 1'b0, 16'h0000},
        // unused mode code runs the biquad
        '{ROW_WRITE,  REG_MODE,       32'(MODE_SECOND_ALT), 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_7FFF, 1'b0, 16'h0000},
        // write to an unused address must not touch the mode
        '{ROW_WRITE,  REG_UNMAPPED,   32'h0000_0000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_1234, 1'b0, 16'h0000},
        // upper bits dropped: lands on bypass
        '{ROW_WRITE,  REG_MODE,       32'hFFFF_FFFC, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_MODE,       32'h0000_1234, 1'b1, 16'h1234}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [SAMPLE_W-1:0]    s_axis_tdata;   // [15:0] sample_in
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [SAMPLE_W-1:0]    m_axis_tdata;   // [15:0] sample_out
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    // filter settings and history as the block should hold them
    logic [MODE_W-1:0]          cfg_mode  = MODE_BYPASS;
    logic [COEF_U_W-1:0]        cfg_first = '0;
    logic [COEF_U_W-1:0]        cfg_b0    = COEF_B0_RESET;
    logic signed [COEF_S_W-1:0] cfg_a1    = '0;
    logic signed [COEF_S_W-1:0] cfg_a2    = '0;
    logic signed [SAMPLE_W-1:0] x_prev1   = '0;
    logic signed [SAMPLE_W-1:0] x_prev2   = '0;
    logic signed [HIST_W-1:0]   y_prev1   = '0;
    logic signed [HIST_W-1:0]   y_prev2   = '0;

    logic [SAMPLE_W-1:0] expected_samples [$];
    logic [SAMPLE_W-1:0] want_out;
    int                  fail_count  = 0;
    int                  cycle_count = 0;
    int                  send_calm   = 0;

    iir_highpass_filter_core DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Filter one sample and advance the history.
    function automatic logic [SAMPLE_W-1:0] filter_sample(input logic signed [SAMPLE_W-1:0] x);
        longint acc;
        longint y;
        longint o;
        if (cfg_mode == MODE_BYPASS)
            return x;
        if (cfg_mode == MODE_FIRST)
            acc = longint'(cfg_first)
                * (longint'(y_prev1) + (longint'(x) - longint'(x_prev1)) * HIST_UP);
        else
            acc = longint'(cfg_b0)
                * ((longint'(x) - 2 * longint'(x_prev1) + longint'(x_prev2)) * HIST_UP)
                - longint'(cfg_a1) * longint'(y_prev1)
                - longint'(cfg_a2) * longint'(y_prev2);
        y = clip(round_half_up(acc, COEF_FRAC_BITS), Y_BOTTOM, Y_TOP);
        if (cfg_mode != MODE_FIRST)
        begin
            x_prev2 = x_prev1;
            y_prev2 = y_prev1;
        end
        x_prev1 = x;
        y_prev1 = y[HIST_W-1:0];
        o = clip(round_half_up(y, HIST_SHIFT), OUT_BOTTOM, OUT_TOP);
        return o[SAMPLE_W-1:0];
    endfunction

    // Mostly no gap, some short ones, a few long; now and then a run with none.
    function automatic int next_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return 0;
            10, 11, 12, 13, 14, 15, 16, 17: return $urandom_range(1, 3);
            default: return $urandom_range(4, 20);
        endcase
    endfunction

    function automatic logic [COEF_S_W-1:0] extreme_coef(input logic [COEF_S_W-1:0] lo,
                                                         input logic [COEF_S_W-1:0] hi);
        case ($urandom_range(0, 2))
            0: return lo;
            1: return hi;
            default: return COEF_S_W'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic known,
                               input logic [SAMPLE_W-1:0] known_out);
        int gap;
        logic [SAMPLE_W-1:0] predicted;
        gap = next_gap(send_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge clk); while (!s_axis_tready);
        predicted = filter_sample(value);
        expected_samples.push_back(known ? known_out : predicted);
    endtask

    // Drain the stream, then write one register.
    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:       cfg_mode  = value[MODE_W-1:0];
            REG_COEF_FIRST: cfg_first = value[COEF_U_W-1:0];
            REG_COEF_B0:    cfg_b0    = value[COEF_U_W-1:0];
            REG_COEF_A1:    cfg_a1    = value[COEF_S_W-1:0];
            REG_COEF_A2:    cfg_a2    = value[COEF_S_W-1:0];
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: output beat %h with nothing expected", $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want_out = expected_samples.pop_front();
                if (m_axis_tdata !== want_out)
                begin
                    $display("%0t: sample_out expected %h actual %h",
                             $time, want_out, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    // output side: random backpressure
    initial
    begin
        int stall;
        int calm;
        calm = 0;
        m_axis_tready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = next_gap(calm);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial
    begin
        int                   phase_kind;
        int                   n_items;
        int                   a1_int;
        int                   a2_int;
        logic [MODE_W-1:0]    n_mode;
        logic [COEF_U_W-1:0]  n_first;
        logic [COEF_U_W-1:0]  n_b0;
        logic [COEF_S_W-1:0]  n_a1;
        logic [COEF_S_W-1:0]  n_a2;
        logic [SAMPLE_W-1:0]  smp;
        logic [SAMPLE_W-1:0]  last_smp;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        last_smp      = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIR_ROWS); i++)
        begin
            if (DIR_ROWS[i].kind == ROW_WRITE)
                write_register(DIR_ROWS[i].idx, DIR_ROWS[i].value);
            else
                send_sample(DIR_ROWS[i].value[SAMPLE_W-1:0], DIR_ROWS[i].known,
                            DIR_ROWS[i].out);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            phase_kind = (phase % 4 == 3) ? 5 : $urandom_range(0, 4);
            n_first = COEF_U_W'($urandom);
            n_b0    = COEF_U_W'($urandom);
            n_a1    = COEF_S_W'($urandom);
            n_a2    = COEF_S_W'($urandom);
            case (phase_kind)
                0: n_mode = MODE_BYPASS;
                1, 2:
                begin
                    n_mode  = MODE_FIRST;
                    n_first = COEF_U_W'($urandom_range(55000, 65536));
                end
                3, 4:
                begin
                    // stable biquad with unity gain at Nyquist
                    n_mode = $urandom_range(0, 1) ? MODE_SECOND : MODE_SECOND_ALT;
                    a2_int = $urandom_range(39000, 64000);
                    a1_int = -int'($urandom_range(65536, 65536 + a2_int - 2000));
                    n_a1   = a1_int[COEF_S_W-1:0];
                    n_a2   = a2_int[COEF_S_W-1:0];
                    n_b0   = COEF_U_W'((65536 - a1_int + a2_int) / 4);
                end
                default:
                begin
                    case ($urandom_range(0, 2))
                        0: n_mode = MODE_FIRST;
                        1: n_mode = MODE_SECOND;
                        default: n_mode = MODE_SECOND_ALT;
                    endcase
                    n_first = COEF_U_W'(extreme_coef('0, 18'h1FFFF));
                    n_b0    = COEF_U_W'(extreme_coef('0, 18'h1FFFF));
                    n_a1    = extreme_coef(18'h20000, 18'h1FFFF);
                    n_a2    = extreme_coef(18'h20000, 18'h1FFFF);
                end
            endcase
            // junk in the upper bits must be dropped
            write_register(REG_COEF_FIRST, ($urandom << COEF_U_W) | 32'(n_first));
            write_register(REG_COEF_B0,    ($urandom << COEF_U_W) | 32'(n_b0));
            write_register(REG_COEF_A1,    ($urandom << COEF_S_W) | 32'(n_a1));
            write_register(REG_COEF_A2,    ($urandom << COEF_S_W) | 32'(n_a2));
            if ($urandom_range(0, 3) == 0)
                write_register(REG_UNMAPPED, $urandom);
            write_register(REG_MODE,       ($urandom << MODE_W) | 32'(n_mode));

            n_items = $urandom_range(100, 180);
            repeat (n_items)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: smp = SAMPLE_W'($urandom);
                    4: smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    5, 6: smp = SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
                    default: smp = last_smp + SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
                endcase
                last_smp = smp;
                send_sample(smp, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
